// ----- sv/tle_pkg.sv -----
// tle_pkg: shared constants, codes, state and command types for the terminal line editor.
// Used by tle_ctrl, tle_datapath, terminal_line_editor and tle_checker.
package tle_pkg;

    // line geometry
    localparam int LINE_CAPACITY = 128;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int CHAR_W        = 8;
    localparam int FIELD_W       = 8;

    // control characters
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_KILL       = 8'd21;
    localparam logic [CHAR_W-1:0] CODE_WORD_ERASE = 8'd23;
    localparam logic [CHAR_W-1:0] CODE_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_PRINT_LOW  = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_PRINT_HIGH = 8'd126;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_TAIL,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // capture input character, clear per-item flags
        logic append;     // store character at line end
        logic drop;       // flag a dropped printable character
        logic kill;       // empty the whole line
        logic pop;        // remove last character, fetch new tail
        logic tail_zero;  // line became empty
        logic tail_load;  // take fetched character as tail
        logic load_out;   // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_print;
        logic is_bs;
        logic is_we;
        logic is_kill;
        logic full;
        logic empty;
        logic cnt_one;
        logic tail_space;
        logic rd_space;
        logic out_free;
    } status_t;

endpackage

// ----- sv/tle_ctrl.sv -----
// tle_ctrl: sequencing state machine of the terminal line editor.
// Depends on tle_pkg for state, command and status types.
module tle_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tle_pkg::status_t  status,
    output tle_pkg::cmd_t     cmd
);

    tle_pkg::state_t state_reg, state_next;
    logic            walk_reg, walk_next;   // word erase walks back to a space

    // state and mode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tle_pkg::ST_IDLE;
            walk_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        walk_next  = walk_reg;
        unique case (state_reg)
            tle_pkg::ST_IDLE: begin
                if (s_valid) state_next = tle_pkg::ST_DECODE;
            end
            tle_pkg::ST_DECODE: begin
                if (status.is_bs && !status.empty) begin
                    state_next = tle_pkg::ST_POP;
                    walk_next  = 1'b0;
                end else if (status.is_we && !status.empty) begin
                    state_next = tle_pkg::ST_POP;
                    walk_next  = !status.tail_space;
                end else begin
                    state_next = tle_pkg::ST_DONE;
                end
            end
            tle_pkg::ST_POP: begin
                state_next = status.cnt_one ? tle_pkg::ST_DONE : tle_pkg::ST_TAIL;
            end
            tle_pkg::ST_TAIL: begin
                if (!walk_reg || status.rd_space || status.cnt_one)
                    state_next = tle_pkg::ST_DONE;
            end
            tle_pkg::ST_DONE: begin
                if (status.out_free) state_next = tle_pkg::ST_IDLE;
            end
            default: state_next = tle_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            tle_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            tle_pkg::ST_DECODE: begin
                cmd.append = status.is_print && !status.full;
                cmd.drop   = status.is_print && status.full;
                cmd.kill   = status.is_kill;
            end
            tle_pkg::ST_POP: begin
                cmd.pop       = 1'b1;
                cmd.tail_zero = status.cnt_one;
            end
            tle_pkg::ST_TAIL: begin
                if (!walk_reg || status.rd_space) begin
                    cmd.tail_load = 1'b1;
                end else begin
                    // keep walking: drop another character
                    cmd.pop       = 1'b1;
                    cmd.tail_zero = status.cnt_one;
                end
            end
            tle_pkg::ST_DONE: begin
                cmd.load_out = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- sv/tle_datapath.sv -----
// tle_datapath: line store, length and tail registers, and result register.
// Depends on tle_pkg; driven by tle_ctrl through cmd_t / status_t.
module tle_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tle_pkg::CHAR_W-1:0]     s_char_code,
    input  tle_pkg::cmd_t                  cmd,
    output tle_pkg::status_t               status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_appended,
    output logic                           m_dropped_full,
    output logic [tle_pkg::FIELD_W-1:0]    m_removed_count,
    output logic [tle_pkg::FIELD_W-1:0]    m_line_length,
    output logic [tle_pkg::CHAR_W-1:0]     m_last_char
);

    logic [tle_pkg::CHAR_W-1:0]  line_mem [tle_pkg::LINE_CAPACITY];
    logic [tle_pkg::CHAR_W-1:0]  code_reg;
    logic [tle_pkg::CHAR_W-1:0]  rd_data_reg;
    logic [tle_pkg::CHAR_W-1:0]  tail_reg, tail_next;
    logic [tle_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tle_pkg::CNT_W-1:0]   removed_reg, removed_next;
    logic                        appended_reg, dropped_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [tle_pkg::CNT_W-1:0]   count_m2;
    logic [tle_pkg::ADDR_W-1:0]  rd_addr;
    logic [tle_pkg::ADDR_W-1:0]  wr_addr;

    // new tail after a pop sits two below the current length
    assign count_m2 = count_reg - tle_pkg::CNT_W'(2);
    assign rd_addr  = count_m2[tle_pkg::ADDR_W-1:0];
    assign wr_addr  = count_reg[tle_pkg::ADDR_W-1:0];

    // line store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.append) line_mem[wr_addr] <= code_reg;
        rd_data_reg <= line_mem[rd_addr];
    end

    // length, tail and removed counter
    always_comb begin
        count_next   = count_reg;
        tail_next    = tail_reg;
        removed_next = removed_reg;
        if (cmd.accept) removed_next = '0;
        if (cmd.append) begin
            count_next = count_reg + tle_pkg::CNT_W'(1);
            tail_next  = code_reg;
        end
        if (cmd.kill) begin
            removed_next = count_reg;
            count_next   = '0;
            tail_next    = '0;
        end
        if (cmd.pop) begin
            count_next   = count_reg - tle_pkg::CNT_W'(1);
            removed_next = removed_reg + tle_pkg::CNT_W'(1);
        end
        if (cmd.tail_load) tail_next = rd_data_reg;
        if (cmd.tail_zero) tail_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tail_reg  <= '0;
        end else begin
            count_reg <= count_next;
            tail_reg  <= tail_next;
        end
    end

    // per-item capture and flags
    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        if (cmd.accept) begin
            code_reg     <= s_char_code;
            appended_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end else begin
            if (cmd.append) appended_reg <= 1'b1;
            if (cmd.drop)   dropped_reg  <= 1'b1;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_appended      <= appended_reg;
            m_dropped_full  <= dropped_reg;
            m_removed_count <= tle_pkg::FIELD_W'(removed_reg);
            m_line_length   <= tle_pkg::FIELD_W'(count_reg);
            m_last_char     <= tail_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // status to the controller
    assign status.is_print   = (code_reg >= tle_pkg::CODE_PRINT_LOW) &&
                               (code_reg <= tle_pkg::CODE_PRINT_HIGH);
    assign status.is_bs      = (code_reg == tle_pkg::CODE_BACKSPACE);
    assign status.is_we      = (code_reg == tle_pkg::CODE_WORD_ERASE);
    assign status.is_kill    = (code_reg == tle_pkg::CODE_KILL);
    assign status.full       = (count_reg >= tle_pkg::CNT_W'(tle_pkg::LINE_CAPACITY));
    assign status.empty      = (count_reg == '0);
    assign status.cnt_one    = (count_reg == tle_pkg::CNT_W'(1));
    assign status.tail_space = (tail_reg == tle_pkg::CODE_SPACE);
    assign status.rd_space   = (rd_data_reg == tle_pkg::CODE_SPACE);
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

// ----- sv/terminal_line_editor.sv -----
// terminal_line_editor: line editing with backspace, word erase and line kill.
// Instantiates tle_ctrl and tle_datapath; depends on tle_pkg.
//
// Usage: one received character byte enters on s_char_code per transfer
// (s_valid/s_ready). Each character yields exactly one result transfer on
// m_* (m_valid/m_ready) describing the line after the edit: appended and
// dropped_full flags, number of characters erased, new length, last char.
// Word erase removes characters until it stops at a space or reaches the
// line start. The word-erase walk reads one character per cycle from the
// line store with registered read data. One character is worked on at a
// time; s_ready is high only while the editor is idle.
// Results sit in an output register: if the receiver stalls, the next item
// is still edited, but its result waits in the datapath until the output
// register is free, and only then does the editor go idle again.
// Reset (aresetn low, synchronous) empties the line and drops any pending
// result; the store contents are not cleared and need no clearing pass.
module terminal_line_editor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tle_pkg::CHAR_W-1:0]    s_char_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_appended,
    output logic                          m_dropped_full,
    output logic [tle_pkg::FIELD_W-1:0]   m_removed_count,
    output logic [tle_pkg::FIELD_W-1:0]   m_line_length,
    output logic [tle_pkg::CHAR_W-1:0]    m_last_char
);

    tle_pkg::cmd_t    cmd;
    tle_pkg::status_t status;

    tle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tle_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_char_code     (s_char_code),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_appended      (m_appended),
        .m_dropped_full  (m_dropped_full),
        .m_removed_count (m_removed_count),
        .m_line_length   (m_line_length),
        .m_last_char     (m_last_char)
    );

endmodule

// ----- sv/tle_checker.sv -----
// tle_checker: port-level assertions for terminal_line_editor, bound to the top level.
// Depends on tle_pkg for character codes and field widths.
module tle_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_appended,
    input logic                          m_dropped_full,
    input logic [tle_pkg::FIELD_W-1:0]   m_removed_count,
    input logic [tle_pkg::FIELD_W-1:0]   m_line_length,
    input logic [tle_pkg::CHAR_W-1:0]    m_last_char
);

    // a printable character is either stored or dropped, never both
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_appended && m_dropped_full))
        else $error("appended and dropped_full both set");

    // appending never erases
    a_append_no_erase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_appended) |-> (m_removed_count == '0))
        else $error("append reported removed characters");

    // empty line reports a zero tail
    a_empty_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_line_length == '0)) |-> (m_last_char == '0))
        else $error("empty line with nonzero last_char");

    // appended character is printable and becomes the tail
    a_append_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_appended) |->
            ((m_last_char >= tle_pkg::CODE_PRINT_LOW) &&
             (m_last_char <= tle_pkg::CODE_PRINT_HIGH) && (m_line_length != '0)))
        else $error("appended tail not printable");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_appended      (m_appended),
    .m_dropped_full  (m_dropped_full),
    .m_removed_count (m_removed_count),
    .m_line_length   (m_line_length),
    .m_last_char     (m_last_char)
);
